// ----- rtl/lbps_pkg.sv -----
// Package for the LED blink priority scheduler: sizes, request codes, per-LED state types.
`default_nettype none
package lbps_pkg;

    localparam int NUM_LEDS = 16;
    localparam int LED_IW   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int OUT_LEDS = 16;

    localparam logic [15:0] FOREVER_LOOPS = 16'hFFFF;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_START  = 2'd1,
        REQ_STOP   = 2'd2,
        REQ_ENABLE = 2'd3
    } t_req;

    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] on;
        logic [15:0] off;
        logic [15:0] loops;
    } t_pat;

    typedef struct packed {
        logic        valid;
        logic        level;
        logic        enabled;
        logic        saved;
        logic        bak_valid;
        logic        bak_saved;
        t_pat        act;
        t_pat        bak;
        logic [16:0] phase;
    } t_led;

endpackage
`default_nettype wire

// ----- rtl/led_blink_priority_scheduler.sv -----
// Top level of the LED blink priority scheduler: request sequencer, LED state store, output word.
// Tick word: captured, then walked one LED per cycle through the shared step unit,
//   then the result is posted to the output word.
// Start, stop and enable words: capture, one LED update, post.
// One word in flight; the next is accepted once the sequencer is back in idle.
// Synchronous active-low reset: all patterns inactive, no backups, all LEDs enabled and dark.
`default_nettype none
module led_blink_priority_scheduler
    import lbps_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // led_index[3:0], priority_req[11:4], on_time[27:12], off_time[43:28],
    // loop_count[59:44], enable_value[60], zero[63:61]
    input  wire  [63:0] i_s_tdata,
    // req_type[1:0]
    input  wire  [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // led_levels[15:0], active_mask[31:16]
    output logic [31:0] o_m_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_REQ,
        S_FIN
    } t_state;

    localparam logic [LED_IW-1:0] LAST_LED = LED_IW'(NUM_LEDS - 1);

    t_state            r_state;
    logic [LED_IW-1:0] r_addr;
    t_req              r_req;
    t_pat              r_new;
    logic              r_en_val;
    logic              r_in_range;
    logic              r_out_valid;
    logic [31:0]       r_out_data;

    logic [NUM_LEDS-1:0] r_act_valid;
    logic [NUM_LEDS-1:0] r_level;
    logic [NUM_LEDS-1:0] r_enabled;
    logic [NUM_LEDS-1:0] r_saved;
    logic [NUM_LEDS-1:0] r_bak_valid;
    logic [NUM_LEDS-1:0] r_bak_saved;
    t_pat                r_act_pat [NUM_LEDS];
    t_pat                r_bak_pat [NUM_LEDS];
    logic [16:0]         r_phase   [NUM_LEDS];

    t_led  rd_st;
    t_led  unit_in;
    t_led  unit_out;
    t_led  wr_st;
    t_led  ld_st;
    logic  unit_incr;
    logic  unit_wrap;
    logic  we;
    logic  accept;
    logic  push;
    logic  ignore;
    logic  [OUT_LEDS-1:0] levels;
    logic  [OUT_LEDS-1:0] active;

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        rd_st.valid     = r_act_valid[r_addr];
        rd_st.level     = r_level[r_addr];
        rd_st.enabled   = r_enabled[r_addr];
        rd_st.saved     = r_saved[r_addr];
        rd_st.bak_valid = r_bak_valid[r_addr];
        rd_st.bak_saved = r_bak_saved[r_addr];
        rd_st.act       = r_act_pat[r_addr];
        rd_st.bak       = r_bak_pat[r_addr];
        rd_st.phase     = r_phase[r_addr];
    end

    lbps_step u_step (
        .i_st   (unit_in),
        .i_incr (unit_incr),
        .i_wrap (unit_wrap),
        .o_st   (unit_out)
    );

    assign push   = rd_st.valid && (r_new.prio > rd_st.act.prio);
    assign ignore = rd_st.valid && (r_new.prio < rd_st.act.prio);

    always_comb begin
        ld_st = rd_st;
        if (push) begin
            ld_st.bak_valid = 1'b1;
            ld_st.bak       = rd_st.act;
            ld_st.bak_saved = rd_st.saved;
        end else begin
            ld_st.saved = rd_st.level;
        end
        ld_st.valid = 1'b1;
        ld_st.act   = r_new;
        ld_st.phase = 17'd0;
    end

    always_comb begin
        unit_in   = rd_st;
        unit_incr = 1'b0;
        unit_wrap = 1'b0;
        wr_st     = rd_st;
        we        = 1'b0;
        case (r_state)
            S_WALK: begin
                we = 1'b1;
                if (!rd_st.enabled) begin
                    wr_st.level = 1'b0;
                    wr_st.valid = 1'b0;
                end else if (rd_st.valid) begin
                    unit_incr = 1'b1;
                    unit_wrap = 1'b1;
                    wr_st     = unit_out;
                end
            end
            S_REQ: begin
                unit_in = ld_st;
                if (r_in_range) begin
                    case (r_req)
                        REQ_START: begin
                            wr_st = ld_st;
                            we    = !ignore;
                            if (rd_st.enabled) begin
                                wr_st.level = unit_out.level;
                            end
                        end
                        REQ_STOP: begin
                            we          = 1'b1;
                            wr_st.valid = 1'b0;
                            wr_st.level = rd_st.saved;
                        end
                        REQ_ENABLE: begin
                            we            = 1'b1;
                            wr_st.enabled = r_en_val;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < OUT_LEDS; gi++) begin : g_out
            if (gi < NUM_LEDS) begin : g_led
                assign levels[gi] = r_level[gi];
                assign active[gi] = r_act_valid[gi];
            end else begin : g_none
                assign levels[gi] = 1'b0;
                assign active[gi] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (t_req'(i_s_tuser[1:0]) == REQ_TICK) begin
                            r_addr  <= '0;
                            r_state <= S_WALK;
                        end else begin
                            r_addr  <= LED_IW'(i_s_tdata[3:0]);
                            r_state <= S_REQ;
                        end
                    end
                end
                S_WALK: begin
                    r_addr <= r_addr + LED_IW'(1);
                    if (r_addr == LAST_LED) begin
                        r_state <= S_FIN;
                    end
                end
                S_REQ: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {active, levels};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req      <= t_req'(i_s_tuser[1:0]);
            r_new.prio <= i_s_tdata[11:4];
            r_new.on   <= i_s_tdata[27:12];
            r_new.off  <= i_s_tdata[43:28];
            r_new.loops <= (i_s_tdata[59:44] == 16'd0) ? 16'd1 : i_s_tdata[59:44];
            r_en_val   <= i_s_tdata[60];
            r_in_range <= (32'(i_s_tdata[3:0]) < 32'(NUM_LEDS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_valid <= '0;
            r_level     <= '0;
            r_enabled   <= '1;
            r_saved     <= '0;
            r_bak_valid <= '0;
            r_bak_saved <= '0;
        end else if (we) begin
            r_act_valid[r_addr] <= wr_st.valid;
            r_level[r_addr]     <= wr_st.level;
            r_enabled[r_addr]   <= wr_st.enabled;
            r_saved[r_addr]     <= wr_st.saved;
            r_bak_valid[r_addr] <= wr_st.bak_valid;
            r_bak_saved[r_addr] <= wr_st.bak_saved;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_act_pat[r_addr] <= wr_st.act;
            r_bak_pat[r_addr] <= wr_st.bak;
            r_phase[r_addr]   <= wr_st.phase;
        end
    end

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_tready)
        else $error("second word accepted while one is in flight");

    a_walk_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_addr != LAST_LED) |=>
            (r_state == S_WALK && r_addr == $past(r_addr) + LED_IW'(1)))
        else $error("LED walk skipped or stopped early");

    a_post_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == S_FIN))
        else $error("result posted outside the finish step");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state == S_WALK || r_state == S_REQ))
        else $error("LED state written while not processing a word");

endmodule
`default_nettype wire

// ----- rtl/lbps_step.sv -----
// Shared per-LED pattern step: phase advance, level decision, wrap and backup resume.
`default_nettype none
module lbps_step
    import lbps_pkg::*;
(
    input  t_led i_st,
    input  logic i_incr,
    input  logic i_wrap,
    output t_led o_st
);

    logic [16:0] period;
    logic        wrapped;
    t_led        s;

    assign period = {1'b0, i_st.act.on} + {1'b0, i_st.act.off};

    always_comb begin
        s       = i_st;
        wrapped = 1'b0;
        if (i_incr) begin
            s.phase = s.phase + 17'd1;
        end
        if (s.phase == 17'd0 && s.act.on != 16'd0) begin
            s.level = 1'b1;
        end else if (s.phase == {1'b0, s.act.on} && s.act.off != 16'd0) begin
            s.level = 1'b0;
        end else if (i_wrap && s.phase >= period) begin
            wrapped = 1'b1;
            if (s.act.loops != FOREVER_LOOPS) begin
                s.act.loops = s.act.loops - 16'd1;
            end
            s.phase = 17'd0;
            if (s.act.loops == 16'd0) begin
                if (s.bak_valid) begin
                    s.act       = s.bak;
                    s.saved     = s.bak_saved;
                    s.bak_valid = 1'b0;
                end else begin
                    s.valid = 1'b0;
                    s.level = s.saved;
                end
            end
        end
        // after a wrap, redo the phase-0 level: lit if on != 0, dark if off != 0
        if (wrapped && s.valid) begin
            if (s.act.on != 16'd0) begin
                s.level = 1'b1;
            end else if (s.act.off != 16'd0) begin
                s.level = 1'b0;
            end
        end
        o_st = s;
    end

endmodule
`default_nettype wire
